FILE: rtl/utf8_validate_and_sanitize_defines.svh
// Assertion macros for the UTF-8 validate and sanitize block.
// Standalone header; used by the top level only.
`ifndef UTF8_VALIDATE_AND_SANITIZE_DEFINES_SVH
`define UTF8_VALIDATE_AND_SANITIZE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define UVS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define UVS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UVS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UVS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/utf8vs_pkg.sv
// Shared types, constants and helpers for the UTF-8 validate and sanitize block.
// No dependencies.
`timescale 1ns / 1ps

package utf8vs_pkg;

  // config port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic        CFG_IDX_REPLACE_MODE = 1'b0;  // paddr[2] of replace_mode

  // U+FFFD as UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;
  localparam logic [1:0] REPL_LAST_IDX = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_REP,
    S_CPY,
    S_VERD
  } state_t;

  // checker verdict on the head of the window
  typedef struct packed {
    logic [2:0] len;        // announced length, 0 for a bad lead
    logic       bad_lead;
    logic       truncated;  // more bytes announced than held
    logic       ok;         // complete sequence passes all checks
  } chk_t;

  // sequencer status to the top level
  typedef struct packed {
    logic       idle;
    logic [2:0] cnt;
  } stat_t;

  function automatic logic [7:0] repl_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = REPL_B0;
      2'd1:    b = REPL_B1;
      default: b = REPL_B2;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/utf8vs_ifs.sv
// Valid/ready channel interfaces for input bytes and result words.
// Depends on nothing.
`timescale 1ns / 1ps

interface utf8vs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface utf8vs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_string;
  logic       string_valid;
  modport source (output valid, out_byte, has_byte, end_of_string, string_valid,
                  input ready);
  modport sink   (input valid, out_byte, has_byte, end_of_string, string_valid,
                  output ready);
endinterface

FILE: rtl/utf8vs_chk.sv
// Sequence checker: decodes the lead byte at the head of the window and checks
// continuation bytes, overlong forms, range and surrogates. Uses utf8vs_pkg.
`timescale 1ns / 1ps

module utf8vs_chk (
  input  logic [3:0][7:0]    win,
  input  logic [2:0]         cnt,
  output utf8vs_pkg::chk_t   res
);

  logic [7:0]  b0;
  logic [2:0]  len;
  logic        c1, c2, c3;
  logic [10:0] cp2;
  logic [15:0] cp3;
  logic [20:0] cp4;
  logic        ok2, ok3, ok4;

  always_comb begin
    b0 = win[0];
    if (b0[7] == 1'b0)               len = 3'd1;
    else if (b0[7:5] == 3'b110)      len = 3'd2;
    else if (b0[7:4] == 4'b1110)     len = 3'd3;
    else if (b0[7:3] == 5'b11110)    len = 3'd4;
    else                             len = 3'd0;

    c1 = (win[1][7:6] == 2'b10);
    c2 = (win[2][7:6] == 2'b10);
    c3 = (win[3][7:6] == 2'b10);

    cp2 = {b0[4:0], win[1][5:0]};
    cp3 = {b0[3:0], win[1][5:0], win[2][5:0]};
    cp4 = {b0[2:0], win[1][5:0], win[2][5:0], win[3][5:0]};

    ok2 = c1 && (cp2 >= 11'h080);
    ok3 = c1 && c2 && (cp3 >= 16'h0800) && !((cp3 >= 16'hD800) && (cp3 <= 16'hDFFF));
    ok4 = c1 && c2 && c3 && (cp4 >= 21'h10000) && (cp4 <= 21'h10FFFF);

    res.len       = len;
    res.bad_lead  = (len == 3'd0);
    res.truncated = (len != 3'd0) && (len > cnt);
    case (len)
      3'd1:    res.ok = 1'b1;
      3'd2:    res.ok = ok2;
      3'd3:    res.ok = ok3;
      3'd4:    res.ok = ok4;
      default: res.ok = 1'b0;
    endcase
  end

endmodule

FILE: rtl/utf8vs_ctl.sv
// Sequencer: holds the byte window, steps the shared checker over it and
// drives the registered result stage. Uses utf8vs_pkg, utf8vs_ifs, utf8vs_chk.
`timescale 1ns / 1ps

module utf8vs_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                replace_mode,
  utf8vs_in_if.sink           in_if,
  utf8vs_out_if.source        out_if,
  output utf8vs_pkg::stat_t   stat
);

  utf8vs_pkg::state_t state_r, state_nxt;
  logic [3:0][7:0] win_r, win_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic            last_r, last_nxt;
  logic            err_r, err_nxt;
  logic            term_r, term_nxt;
  logic [2:0]      ecnt_r, ecnt_nxt;
  logic [1:0]      ridx_r, ridx_nxt;

  logic            ov_r, ov_nxt;
  logic [7:0]      ob_r, ob_nxt;
  logic            oh_r, oh_nxt;
  logic            oe_r, oe_nxt;
  logic            os_r, os_nxt;

  logic            slot_free;
  utf8vs_pkg::chk_t chk;

  utf8vs_chk u_chk (
    .win (win_r),
    .cnt (cnt_r),
    .res (chk)
  );

  assign slot_free = !ov_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= utf8vs_pkg::S_IDLE;
      cnt_r   <= 3'd0;
      err_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    last_r <= last_nxt;
    term_r <= term_nxt;
    ecnt_r <= ecnt_nxt;
    ridx_r <= ridx_nxt;
    ob_r   <= ob_nxt;
    oh_r   <= oh_nxt;
    oe_r   <= oe_nxt;
    os_r   <= os_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    win_nxt   = win_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    err_nxt   = err_r;
    term_nxt  = term_r;
    ecnt_nxt  = ecnt_r;
    ridx_nxt  = ridx_r;
    ov_nxt    = ov_r && !out_if.ready;
    ob_nxt    = ob_r;
    oh_nxt    = oh_r;
    oe_nxt    = oe_r;
    os_nxt    = os_r;

    unique case (state_r)
      utf8vs_pkg::S_IDLE: begin
        if (in_if.valid) begin
          win_nxt[cnt_r[1:0]] = in_if.in_byte;
          cnt_nxt   = cnt_r + 3'd1;
          last_nxt  = in_if.in_last;
          state_nxt = utf8vs_pkg::S_DEC;
        end
      end

      utf8vs_pkg::S_DEC: begin
        if (cnt_r == 3'd0) begin
          state_nxt = last_r ? utf8vs_pkg::S_VERD : utf8vs_pkg::S_IDLE;
        end else if (chk.truncated) begin
          if (last_r) begin
            // cut short at end: one replacement in sanitize mode, held bytes dropped
            err_nxt  = 1'b1;
            cnt_nxt  = 3'd0;
            term_nxt = 1'b1;
            ridx_nxt = 2'd0;
            state_nxt = replace_mode ? utf8vs_pkg::S_REP : utf8vs_pkg::S_VERD;
          end else begin
            state_nxt = utf8vs_pkg::S_IDLE;  // keep as pending
          end
        end else if (chk.bad_lead || !chk.ok) begin
          err_nxt = 1'b1;
          if (replace_mode) begin
            term_nxt  = last_r && (cnt_r == 3'd1);
            ridx_nxt  = 2'd0;
            state_nxt = utf8vs_pkg::S_REP;
          end else begin
            win_nxt = {8'h00, win_r[3], win_r[2], win_r[1]};
            cnt_nxt = cnt_r - 3'd1;
          end
        end else begin
          term_nxt  = last_r && (cnt_r == chk.len);
          ecnt_nxt  = chk.len;
          state_nxt = utf8vs_pkg::S_CPY;
        end
      end

      utf8vs_pkg::S_REP: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          ob_nxt   = utf8vs_pkg::repl_byte(ridx_r);
          oh_nxt   = 1'b1;
          oe_nxt   = term_r && (ridx_r == utf8vs_pkg::REPL_LAST_IDX);
          os_nxt   = 1'b0;
          ridx_nxt = ridx_r + 2'd1;
          if (ridx_r == utf8vs_pkg::REPL_LAST_IDX) begin
            win_nxt = {8'h00, win_r[3], win_r[2], win_r[1]};
            cnt_nxt = cnt_r - 3'd1;
            if (term_r) begin
              cnt_nxt   = 3'd0;
              err_nxt   = 1'b0;
              state_nxt = utf8vs_pkg::S_IDLE;
            end else begin
              state_nxt = utf8vs_pkg::S_DEC;
            end
          end
        end
      end

      utf8vs_pkg::S_CPY: begin
        // validate mode walks the bytes without emitting
        if (!replace_mode || slot_free) begin
          if (replace_mode) begin
            ov_nxt = 1'b1;
            ob_nxt = win_r[0];
            oh_nxt = 1'b1;
            oe_nxt = term_r && (ecnt_r == 3'd1);
            os_nxt = term_r && (ecnt_r == 3'd1) && !err_r;
          end
          win_nxt  = {8'h00, win_r[3], win_r[2], win_r[1]};
          cnt_nxt  = cnt_r - 3'd1;
          ecnt_nxt = ecnt_r - 3'd1;
          if (ecnt_r == 3'd1) begin
            if (replace_mode && term_r) begin
              cnt_nxt   = 3'd0;
              err_nxt   = 1'b0;
              state_nxt = utf8vs_pkg::S_IDLE;
            end else begin
              state_nxt = utf8vs_pkg::S_DEC;
            end
          end
        end
      end

      utf8vs_pkg::S_VERD: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = 8'h00;
          oh_nxt    = 1'b0;
          oe_nxt    = 1'b1;
          os_nxt    = !err_r;
          err_nxt   = 1'b0;
          cnt_nxt   = 3'd0;
          state_nxt = utf8vs_pkg::S_IDLE;
        end
      end

      default: state_nxt = utf8vs_pkg::S_IDLE;
    endcase
  end

  assign in_if.ready          = (state_r == utf8vs_pkg::S_IDLE);
  assign out_if.valid         = ov_r;
  assign out_if.out_byte      = ob_r;
  assign out_if.has_byte      = oh_r;
  assign out_if.end_of_string = oe_r;
  assign out_if.string_valid  = os_r;

  assign stat.idle = (state_r == utf8vs_pkg::S_IDLE);
  assign stat.cnt  = cnt_r;

endmodule

FILE: rtl/utf8_validate_and_sanitize.sv
// UTF-8 validate and sanitize, top level; uses utf8vs_pkg, utf8vs_ifs, utf8vs_ctl.
// Path of a byte: loaded in IDLE, decided in DEC, then the first word is registered.
// At free output each byte takes its load, one decision per sequence start, a step
// per word (validate: per byte walked), a closing decision and the verdict; the
// input is not ready meanwhile.
// Reset: synchronous active-low rst_n; clears pending count, error flag, result valid.
`timescale 1ns / 1ps
`include "utf8_validate_and_sanitize_defines.svh"

module utf8_validate_and_sanitize (
  input  logic                               clk,
  input  logic                               rst_n,
  utf8vs_in_if.sink                          in_if,
  utf8vs_out_if.source                       out_if,
  // APB-style config port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [utf8vs_pkg::CfgAddrW-1:0]    paddr,
  input  logic [utf8vs_pkg::CfgDataW-1:0]    pwdata,
  output logic [utf8vs_pkg::CfgDataW-1:0]    prdata,
  output logic                               pready
);

  // replace_mode: 0 gives one verdict word per string, 1 rewrites bad input
  // as U+FFFD and copies good sequences through; reset value 1 (sanitize)
  logic replace_mode_r;
  logic cfg_wr;
  logic cfg_hit;
  logic verdict_shape;

  utf8vs_pkg::stat_t ctl_stat;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == utf8vs_pkg::CFG_IDX_REPLACE_MODE);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      replace_mode_r <= 1'b1;
    end else if (cfg_wr) begin
      replace_mode_r <= pwdata[0];
    end
  end

  // reads of unmapped words return zero
  assign prdata = cfg_hit ? {{(utf8vs_pkg::CfgDataW-1){1'b0}}, replace_mode_r}
                          : '0;

  // sequencer with shared checker and result register
  utf8vs_ctl u_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .replace_mode (replace_mode_r),
    .in_if        (in_if),
    .out_if       (out_if),
    .stat         (ctl_stat)
  );

  assign verdict_shape = out_if.end_of_string && (out_if.out_byte == 8'h00);

  // while idle, at most three bytes of an open sequence are held
  `UVS_ASSERT_IMP(a_idle_cnt, clk, rst_n, ctl_stat.idle, ctl_stat.cnt <= 3'd3)
  // the verdict only rides on the closing word
  `UVS_ASSERT_IMP(a_sv_on_eos, clk, rst_n, out_if.valid && out_if.string_valid, out_if.end_of_string)
  // a verdict-only word is always the close of a string and carries zero data
  `UVS_ASSERT_IMP(a_verdict_shape, clk, rst_n, out_if.valid && !out_if.has_byte, verdict_shape)
  // a taken byte is always decided in DEC before the input is ready again
  `UVS_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready)

endmodule

FILE: tb/sv/utf8vs_checker.sv
// Scoreboard for utf8_validate_and_sanitize: watches both channels and the config port.
// Predicts the result words of each accepted byte and compares them in order.
// Depends on utf8vs_pkg and the channel interfaces in utf8vs_ifs.sv.
`timescale 1ns / 1ps

module utf8vs_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  utf8vs_in_if                            in_ch,
  utf8vs_out_if                           out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [utf8vs_pkg::CfgAddrW-1:0] paddr,
  input  logic [utf8vs_pkg::CfgDataW-1:0] pwdata,
  output int unsigned                     words_due,
  output int unsigned                     mismatches
);

  localparam logic [utf8vs_pkg::CfgAddrW-1:0] REPLACE_MODE_ADDR =
    {utf8vs_pkg::CFG_IDX_REPLACE_MODE, 2'b00};

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eos;
    logic       ok;
  } word_t;

  word_t       word_q[$];   // words still to come from the block
  word_t       step_q[$];   // words of the byte being decoded
  logic [7:0]  held [0:2];  // start of an incomplete sequence
  int unsigned held_cnt;
  logic        err_flag;
  logic        sanitize;
  int unsigned fails;

  // 0 for a byte that cannot open a sequence
  function automatic int unsigned lead_len(input logic [7:0] c);
    if (c[7] == 1'b0) return 1;
    if (c[7:5] == 3'b110) return 2;
    if (c[7:4] == 4'b1110) return 3;
    if (c[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  function automatic bit seq_ok(input logic [3:0][7:0] s, input int unsigned len);
    logic [31:0] cp;
    int unsigned j;
    if (len == 1) return 1'b1;
    if (len == 2) cp = {27'd0, s[0][4:0]};
    else if (len == 3) cp = {28'd0, s[0][3:0]};
    else cp = {29'd0, s[0][2:0]};
    for (j = 1; j < len; j++) begin
      if (s[j][7:6] != 2'b10) return 1'b0;
      cp = {cp[25:0], s[j][5:0]};
    end
    if (len == 2 && cp < 32'h80) return 1'b0;
    if (len == 3 && cp < 32'h800) return 1'b0;
    if (len == 4 && (cp < 32'h10000 || cp > 32'h10FFFF)) return 1'b0;
    if (cp >= 32'hD800 && cp <= 32'hDFFF) return 1'b0;
    return 1'b1;
  endfunction

  task automatic add_word(input logic [7:0] d, input logic has);
    word_t w;
    w = '{data: d, has_byte: has, eos: 1'b0, ok: 1'b0};
    step_q.push_back(w);
  endtask

  task automatic add_fffd();
    err_flag = 1'b1;
    if (sanitize) begin
      add_word(utf8vs_pkg::REPL_B0, 1'b1);
      add_word(utf8vs_pkg::REPL_B1, 1'b1);
      add_word(utf8vs_pkg::REPL_B2, 1'b1);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [7:0]      win [0:3];
    logic [3:0][7:0] seq;
    int unsigned     n, i, j, len;
    word_t           w;
    step_q.delete();
    for (j = 0; j < held_cnt; j++) win[j] = held[j];
    win[held_cnt] = b;
    n = held_cnt + 1;
    held_cnt = 0;
    i = 0;
    while (i < n) begin
      len = lead_len(win[i]);
      if (len == 0) begin
        add_fffd();
        i++;
      end else if (i + len > n) begin
        // cut short: at the end one error (a replacement when sanitizing), else keep the start
        if (last) add_fffd();
        else begin
          for (j = 0; i + j < n; j++) held[j] = win[i + j];
          held_cnt = n - i;
        end
        i = n;
      end else begin
        for (j = 0; j < 4; j++) seq[j] = (i + j < n) ? win[i + j] : 8'h00;
        if (seq_ok(seq, len)) begin
          if (sanitize)
            for (j = 0; j < len; j++) add_word(win[i + j], 1'b1);
          i += len;
        end else begin
          add_fffd();
          i++;
        end
      end
    end
    if (last) begin
      if (!sanitize || step_q.size() == 0) add_word(8'h00, 1'b0);
      w = step_q[step_q.size() - 1];
      w.eos = 1'b1;
      w.ok  = !err_flag;
      step_q[step_q.size() - 1] = w;
      err_flag = 1'b0;
      held_cnt = 0;
    end
    while (step_q.size() > 0) word_q.push_back(step_q.pop_front());
  endtask

  always @(posedge clk) begin : watch
    word_t want;
    if (!rst_n) begin
      word_q.delete();
      held_cnt = 0;
      err_flag = 1'b0;
      sanitize = 1'b1;
      fails    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REPLACE_MODE_ADDR)
        sanitize = pwdata[0];
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.in_byte, in_ch.in_last);
      if (out_ch.valid && out_ch.ready) begin
        if (word_q.size() == 0) begin
          $error("result word with none expected: out_byte %02h", out_ch.out_byte);
          fails++;
        end else begin
          want = word_q.pop_front();
          if (out_ch.out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_ch.out_byte);
            fails++;
          end
          if (out_ch.has_byte !== want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", want.has_byte, out_ch.has_byte);
            fails++;
          end
          if (out_ch.end_of_string !== want.eos) begin
            $error("end_of_string: expected %0b, got %0b", want.eos, out_ch.end_of_string);
            fails++;
          end
          if (out_ch.string_valid !== want.ok) begin
            $error("string_valid: expected %0b, got %0b", want.ok, out_ch.string_valid);
            fails++;
          end
        end
      end
    end
    words_due  <= word_q.size();
    mismatches <= fails;
  end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the utf8_validate_and_sanitize testbench: clock, reset, byte stimulus,
// config writes, receiver stalls, watchdog and verdict. Checking sits in utf8vs_checker.
// Depends on utf8vs_pkg, utf8vs_ifs.sv, utf8vs_checker.sv and the RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [utf8vs_pkg::CfgAddrW-1:0] REPLACE_MODE_ADDR =
    {utf8vs_pkg::CFG_IDX_REPLACE_MODE, 2'b00};
  localparam logic MODE_VALIDATE = 1'b0;
  localparam logic MODE_SANITIZE = 1'b1;

  localparam int unsigned ITEMS_PER_PHASE = 75;
  localparam int unsigned LONG_HOLD       = 200;  // receiver hold-off, cycles
  localparam int unsigned SETTLE          = 16;   // covers the busy time of a byte that gives no word
  localparam int unsigned END_WAIT        = 32;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  // kinds of character put into a random string
  typedef enum int unsigned {
    CH_ASCII, CH_TWO, CH_THREE, CH_FOUR, CH_OVERLONG, CH_SURROGATE,
    CH_ABOVE_MAX, CH_BAD_LEAD, CH_BAD_CONT, CH_CUT, CH_NOISE
  } char_kind_t;

  logic                            clk;
  logic                            rst_n;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [utf8vs_pkg::CfgAddrW-1:0] paddr;
  logic [utf8vs_pkg::CfgDataW-1:0] pwdata;
  logic [utf8vs_pkg::CfgDataW-1:0] prdata;
  logic                            pready;

  int unsigned words_due;
  int unsigned mismatches;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_left;
  int unsigned quiet;
  logic [7:0]  str_q[$];      // bytes of the string being sent

  utf8vs_in_if  in_ch ();
  utf8vs_out_if out_ch ();

  utf8_validate_and_sanitize u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  utf8vs_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .words_due  (words_due),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Watchdog: too long with no word moving on either channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("[utf8_validate_and_sanitize] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // One byte, with a random gap first; valid stays high after acceptance
  // so back-to-back bytes never drop it within a step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_str(input logic ends);
    int unsigned k;
    for (k = 0; k < str_q.size(); k++)
      send_byte(str_q[k], ends && (k == str_q.size() - 1));
  endtask

  // Stop offering and wait until every predicted word has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  task automatic cfg_write(input logic [utf8vs_pkg::CfgAddrW-1:0] a,
                           input logic [utf8vs_pkg::CfgDataW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A byte that stays inside a held sequence gives no word, so the block may
  // still be busy after the drain: give it its worst-case time first.
  task automatic set_mode(input logic m);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_write(REPLACE_MODE_ADDR, {{(utf8vs_pkg::CfgDataW-1){1'b0}}, m});
  endtask

  // Encode cp in a len-byte form; overlong forms come out of the same path.
  task automatic put_cp(input logic [20:0] cp, input int unsigned len);
    case (len)
      1: str_q.push_back({1'b0, cp[6:0]});
      2: begin
        str_q.push_back({3'b110, cp[10:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_q.push_back({4'b1110, cp[15:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_q.push_back({5'b11110, cp[20:18]});
        str_q.push_back({2'b10, cp[17:12]});
        str_q.push_back({2'b10, cp[11:6]});
        str_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic logic [20:0] valid_cp(input int unsigned len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(21'h7F, 0));
      2: cp = 21'($urandom_range(21'h7FF, 21'h80));
      3: begin
        cp = 21'($urandom_range(21'hFFFF, 21'h800));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h2000;
      end
      default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
    endcase
    return cp;
  endfunction

  task automatic add_char(input char_kind_t kind);
    int unsigned len, s, j, r;
    logic [7:0]  b;
    len = $urandom_range(4, 2);
    s   = str_q.size();
    case (kind)
      CH_ASCII:     put_cp(valid_cp(1), 1);
      CH_TWO:       put_cp(valid_cp(2), 2);
      CH_THREE:     put_cp(valid_cp(3), 3);
      CH_FOUR:      put_cp(valid_cp(4), 4);
      CH_OVERLONG:  put_cp(valid_cp(len - 1), len);
      CH_SURROGATE: put_cp(21'($urandom_range(21'hDFFF, 21'hD800)), 3);
      CH_ABOVE_MAX: put_cp(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
      CH_BAD_LEAD:
        str_q.push_back($urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                          : 8'($urandom_range(8'hFF, 8'hF8)));
      CH_BAD_CONT: begin
        // spoil one continuation byte
        put_cp(valid_cp(len), len);
        j = $urandom_range(s + len - 1, s + 1);
        b = 8'($urandom_range(255));
        if (b[7:6] == 2'b10) b[7] = 1'b0;
        str_q[j] = b;
      end
      CH_CUT: begin
        put_cp(valid_cp(len), len);
        r = $urandom_range(len - 1, 1);
        repeat (r) void'(str_q.pop_back());
      end
      default: repeat ($urandom_range(3, 1)) str_q.push_back(8'($urandom_range(255)));
    endcase
  endtask

  // Mostly well-formed text with random content, the rest broken forms and noise.
  task automatic build_string();
    int unsigned r;
    char_kind_t  kind;
    str_q.delete();
    repeat ($urandom_range(6, 1)) begin
      r = $urandom_range(99);
      if (r < 20)      kind = CH_ASCII;
      else if (r < 35) kind = CH_TWO;
      else if (r < 50) kind = CH_THREE;
      else if (r < 62) kind = CH_FOUR;
      else if (r < 65) kind = CH_OVERLONG;
      else if (r < 68) kind = CH_SURROGATE;
      else if (r < 71) kind = CH_ABOVE_MAX;
      else if (r < 76) kind = CH_BAD_LEAD;
      else if (r < 82) kind = CH_BAD_CONT;
      else if (r < 90) kind = CH_CUT;
      else             kind = CH_NOISE;
      add_char(kind);
    end
  endtask

  initial begin : stimulus
    int unsigned ph, sent;
    bit          paused;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_left     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, sanitize mode from reset.
    str_q = '{8'h00};                              // lowest byte alone
    send_str(1'b1);
    str_q = '{8'hFF};                              // bad lead as the whole string
    send_str(1'b1);
    // two-, three- and four-byte forms, the last one U+10FFFF
    str_q = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_str(1'b1);
    str_q = '{8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80};  // overlong, then a surrogate
    send_str(1'b1);
    // cut short at the end: one replacement even with a bad continuation held
    str_q = '{8'hE2, 8'h41};
    send_str(1'b1);

    cfg_write_validate: begin
      set_mode(MODE_VALIDATE);
      str_q = '{8'hC3, 8'hA9};
      send_str(1'b1);
    end
    // mode change mid-string: start held in validate, finished in sanitize
    str_q = '{8'hE2, 8'h82};
    send_str(1'b0);
    set_mode(MODE_SANITIZE);
    str_q = '{8'hAC, 8'h80};
    send_str(1'b1);

    // Random part: four idling phases, modes alternating.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 77; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 77; end
        default: begin src_idle_pct = 25; snk_stall_pct = 25; end
      endcase
      set_mode((ph % 2 == 1) ? MODE_VALIDATE : MODE_SANITIZE);
      // long receiver hold-off while bytes keep coming, to back up the input
      if (ph == 0) hold_left = LONG_HOLD;
      sent   = 0;
      paused = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        build_string();
        send_str(1'b1);
        sent += str_q.size();
        // sender pause until the block has emptied out
        if (ph == 2 && !paused && sent >= ITEMS_PER_PHASE / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0 && words_due == 0) begin
      $display("[utf8_validate_and_sanitize] OK");
    end else begin
      $display("[utf8_validate_and_sanitize] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/utf8vs_pkg.sv
rtl/utf8vs_ifs.sv
rtl/utf8vs_chk.sv
rtl/utf8vs_ctl.sv
rtl/utf8_validate_and_sanitize.sv
tb/sv/utf8vs_checker.sv
tb/sv/tb_top.sv
